// File: hw/rtl/rtwa_pkg.sv
// Shared types, constants and codes of the rain tip window accumulator.
`default_nettype none
package rtwa_pkg;

  // Ring geometry and derived widths.
  localparam int BUCKETS = 64;
  localparam int IDX_W   = $clog2(BUCKETS);
  localparam int MS_W    = 32;
  localparam int CNT_W   = 16;
  localparam int CFG_W   = 16;
  localparam int TIPS_W  = IDX_W + CNT_W;   // room for every bucket at full count
  localparam int AMT_W   = TIPS_W + CFG_W;  // tips times rain per tip
  localparam int PROD_W  = AMT_W + MS_W;    // amount times window
  localparam int TOTAL_W = 22;
  localparam int DIV_STEPS = MS_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [MS_W-1:0]    MAX32     = 32'hFFFF_FFFF;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = 22'h3F_FFFF;
  localparam logic [CNT_W-1:0]   COUNT_MAX = 16'hFFFF;

  // Item kinds carried on the input tuser.
  localparam logic [1:0] OP_TIP   = 2'd0;
  localparam logic [1:0] OP_QUERY = 2'd1;
  localparam logic [1:0] OP_START = 2'd2;

  // Configuration register indexes and reset values.
  localparam logic [1:0] CFG_DEBOUNCE = 2'd0;
  localparam logic [1:0] CFG_RAIN     = 2'd1;
  localparam logic [1:0] CFG_PERIOD   = 2'd2;
  localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd100;
  localparam logic [CFG_W-1:0] RAIN_RST     = 16'd279;
  localparam logic [CFG_W-1:0] PERIOD_RST   = 16'd1000;

  // One ring entry as stored in the bucket memory.
  typedef struct packed {
    logic [MS_W-1:0]  stamp;
    logic [CNT_W-1:0] count;
  } bucket_t;

  localparam int BUCKET_W = $bits(bucket_t);

  // Request to and answer from the scaling unit.
  typedef struct packed {
    logic [TIPS_W-1:0] tips;
    logic [CFG_W-1:0]  rpt;
    logic [MS_W-1:0]   win;
    logic [MS_W-1:0]   span;
  } scale_req_t;

  typedef struct packed {
    logic [MS_W-1:0] rain;
    logic            sat;
    logic            zero;
  } scale_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TIP,
    ST_WALK,
    ST_DRAIN,
    ST_ADV,
    ST_SCALE,
    ST_DONE
  } top_state_t;

  typedef enum logic [2:0] {
    SC_IDLE,
    SC_AMT,
    SC_MLO,
    SC_MHI,
    SC_SUM,
    SC_CHK,
    SC_DIV,
    SC_DONE
  } scale_state_t;

endpackage
`default_nettype wire

// File: hw/rtl/rtwa_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module rtwa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/rtwa_scale.sv
// Scaling: amount*window/span (clipped amount if span is 0), split multiply, serial divide.
`default_nettype none
module rtwa_scale (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               go,
  input  wire rtwa_pkg::scale_req_t req,
  output      logic               done,
  output      rtwa_pkg::scale_rsp_t rsp
);
  import rtwa_pkg::*;

  scale_state_t state_r, state_nxt;

  logic [TIPS_W-1:0]    tips_r, tips_nxt;
  logic [CFG_W-1:0]     rpt_r, rpt_nxt;
  logic [MS_W-1:0]      win_r, win_nxt;
  logic [MS_W-1:0]      span_r, span_nxt;
  logic [AMT_W-1:0]     amt_r, amt_nxt;
  logic [2*MS_W-1:0]    plo_r, plo_nxt;
  logic [AMT_W-1:0]     phi_r, phi_nxt;
  logic [PROD_W-1:0]    prod_r, prod_nxt;
  logic [MS_W-1:0]      rem_r, rem_nxt;
  logic [MS_W-1:0]      quo_r, quo_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [MS_W-1:0]      rain_r, rain_nxt;
  logic                 sat_r, sat_nxt;
  logic                 zero_r, zero_nxt;
  logic [MS_W:0]        trial;
  logic                 ge;

  // One restoring step: bring down the next dividend bit and try the subtract.
  assign trial = {rem_r, quo_r[MS_W-1]};
  assign ge    = (trial >= {1'b0, span_r});

  always_comb begin
    state_nxt = state_r;
    tips_nxt  = tips_r;
    rpt_nxt   = rpt_r;
    win_nxt   = win_r;
    span_nxt  = span_r;
    amt_nxt   = amt_r;
    plo_nxt   = plo_r;
    phi_nxt   = phi_r;
    prod_nxt  = prod_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    cnt_nxt   = cnt_r;
    rain_nxt  = rain_r;
    sat_nxt   = sat_r;
    zero_nxt  = zero_r;
    done      = 1'b0;
    case (state_r)
      SC_IDLE: begin
        if (go) begin
          tips_nxt  = req.tips;
          rpt_nxt   = req.rpt;
          win_nxt   = req.win;
          span_nxt  = req.span;
          state_nxt = SC_AMT;
        end
      end
      SC_AMT: begin
        amt_nxt   = AMT_W'(tips_r) * AMT_W'(rpt_r);
        zero_nxt  = (span_r == '0);
        state_nxt = SC_MLO;
      end
      SC_MLO: begin
        if (zero_r) begin
          // No correction possible: report the plain amount, clipped.
          if (amt_r > AMT_W'(MAX32)) begin
            rain_nxt = MAX32;
            sat_nxt  = 1'b1;
          end else begin
            rain_nxt = amt_r[MS_W-1:0];
            sat_nxt  = 1'b0;
          end
          state_nxt = SC_DONE;
        end else begin
          plo_nxt   = (2*MS_W)'(amt_r[MS_W-1:0]) * (2*MS_W)'(win_r);
          state_nxt = SC_MHI;
        end
      end
      SC_MHI: begin
        phi_nxt   = AMT_W'(amt_r[AMT_W-1:MS_W]) * AMT_W'(win_r);
        state_nxt = SC_SUM;
      end
      SC_SUM: begin
        prod_nxt  = {phi_r, {MS_W{1'b0}}} + PROD_W'(plo_r);
        state_nxt = SC_CHK;
      end
      SC_CHK: begin
        // The quotient reaches 2^32 exactly when the upper product part reaches the span.
        if (prod_r[PROD_W-1:MS_W] >= AMT_W'(span_r)) begin
          rain_nxt  = MAX32;
          sat_nxt   = 1'b1;
          state_nxt = SC_DONE;
        end else begin
          rem_nxt   = prod_r[2*MS_W-1:MS_W];
          quo_nxt   = prod_r[MS_W-1:0];
          cnt_nxt   = '0;
          sat_nxt   = 1'b0;
          state_nxt = SC_DIV;
        end
      end
      SC_DIV: begin
        rem_nxt = ge ? MS_W'(trial - {1'b0, span_r}) : trial[MS_W-1:0];
        quo_nxt = {quo_r[MS_W-2:0], ge};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          rain_nxt  = {quo_r[MS_W-2:0], ge};
          state_nxt = SC_DONE;
        end
      end
      SC_DONE: begin
        done      = 1'b1;
        state_nxt = SC_IDLE;
      end
      default: begin
        state_nxt = SC_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SC_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tips_r <= tips_nxt;
    rpt_r  <= rpt_nxt;
    win_r  <= win_nxt;
    span_r <= span_nxt;
    amt_r  <= amt_nxt;
    plo_r  <= plo_nxt;
    phi_r  <= phi_nxt;
    prod_r <= prod_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    cnt_r  <= cnt_nxt;
    rain_r <= rain_nxt;
    sat_r  <= sat_nxt;
    zero_r <= zero_nxt;
  end

  assign rsp.rain = rain_r;
  assign rsp.sat  = sat_r;
  assign rsp.zero = zero_r;

endmodule
`default_nettype wire

// File: hw/rtl/rain_tip_window_accumulator.sv
// Top level of the rain tip window accumulator: bucket ring, event sequencer and result register.
`default_nettype none
// The block counts rain gauge tips into a ring of 64 time buckets kept in one
// synchronous RAM (stamp and count per entry) and answers window queries. Each
// input item carries its kind on in_tuser: a tip reads the current bucket and
// writes it back (nothing happens when the debounce rejects it), a start
// clears a per-entry valid bit vector at once, so the ring reads as empty,
// and stamps the current bucket, and a query makes one RAM read per bucket to
// form the tip sum and the oldest counted stamp, then runs the scaling unit
// with its 32-step serial divider. Only a query produces a result item; it
// waits in an output register, so tips and starts are taken while it is still
// pending. The result is floor(tips * rain_per_tip * window / span), clipped
// at 2^32-1 with the saturated flag; a zero span gives the unscaled amount with
// zero_span set. Configuration writes are always accepted and should be made
// while idle.
module rain_tip_window_accumulator (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input items.
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [63:0] in_tdata,   // now_ms [31:0], window_ms [63:32]
  input  wire logic [1:0]  in_tuser,   // op [1:0]
  // Result items.
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [55:0] out_tdata,  // rain_um [31:0], tip_total [53:32], zero pad
  output      logic [1:0]  out_tuser,  // zero_span [0], saturated [1]
  // Configuration writes.
  input  wire logic        cfg_valid,
  output      logic        cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  import rtwa_pkg::*;

  top_state_t state_r, state_nxt;

  // Configuration registers.
  logic [CFG_W-1:0] debounce_r, debounce_nxt;
  logic [CFG_W-1:0] rpt_r, rpt_nxt;
  logic [CFG_W-1:0] period_r, period_nxt;

  // Scalar state and per-entry valid bits of the ring.
  logic [IDX_W-1:0]   cur_r, cur_nxt;
  logic [MS_W-1:0]    last_tip_r, last_tip_nxt;
  logic [BUCKETS-1:0] valid_r, valid_nxt;

  // Query working registers.
  logic [MS_W-1:0]   now_r, now_nxt;
  logic [MS_W-1:0]   win_r, win_nxt;
  logic [MS_W-1:0]   wstart_r, wstart_nxt;
  logic [TIPS_W-1:0] tips_r, tips_nxt;
  logic [MS_W-1:0]   oldest_r, oldest_nxt;
  logic [MS_W-1:0]   cur_stamp_r, cur_stamp_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              acc_v_r, acc_v_nxt;
  logic [IDX_W-1:0]  acc_idx_r, acc_idx_nxt;

  // Result register.
  logic               out_valid_r, out_valid_nxt;
  logic [MS_W-1:0]    out_rain_r, out_rain_nxt;
  logic [TOTAL_W-1:0] out_total_r, out_total_nxt;
  logic               out_zero_r, out_zero_nxt;
  logic               out_sat_r, out_sat_nxt;

  // Bucket memory ports.
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  bucket_t          mem_wdata;
  logic             mem_re;
  logic [IDX_W-1:0] mem_raddr;
  logic [BUCKET_W-1:0] mem_rdata;
  bucket_t          rd_bucket;
  bucket_t          tip_bucket;

  // Scaling unit.
  logic       scale_go;
  logic       scale_done;
  scale_req_t scale_req;
  scale_rsp_t scale_rsp;

  logic            in_acc;
  logic [1:0]      in_op;
  logic [MS_W-1:0] in_now;
  logic [MS_W-1:0] in_win;
  logic            tip_ok;
  logic [IDX_W-1:0] cur_inc;

  assign in_op  = in_tuser;
  assign in_now = in_tdata[MS_W-1:0];
  assign in_win = in_tdata[2*MS_W-1:MS_W];
  assign in_acc = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_IDLE);

  // Debounce: elapsed time since the last accepted tip, modulo 2^32.
  assign tip_ok = ((in_now - last_tip_r) >= MS_W'(debounce_r));

  assign cur_inc = (cur_r == IDX_W'(BUCKETS - 1)) ? '0 : cur_r + 1'b1;

  // An entry never written since the last start reads as all zero.
  assign rd_bucket  = valid_r[acc_idx_r] ? bucket_t'(mem_rdata) : '0;
  assign tip_bucket = valid_r[cur_r] ? bucket_t'(mem_rdata) : '0;

  assign cfg_ready = 1'b1;

  always_comb begin
    debounce_nxt = debounce_r;
    rpt_nxt      = rpt_r;
    period_nxt   = period_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DEBOUNCE: debounce_nxt = cfg_data;
        CFG_RAIN:     rpt_nxt      = cfg_data;
        CFG_PERIOD:   period_nxt   = cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    last_tip_nxt  = last_tip_r;
    valid_nxt     = valid_r;
    now_nxt       = now_r;
    win_nxt       = win_r;
    wstart_nxt    = wstart_r;
    tips_nxt      = tips_r;
    oldest_nxt    = oldest_r;
    cur_stamp_nxt = cur_stamp_r;
    idx_nxt       = idx_r;
    acc_v_nxt     = (state_r == ST_WALK);
    acc_idx_nxt   = idx_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_rain_nxt  = out_rain_r;
    out_total_nxt = out_total_r;
    out_zero_nxt  = out_zero_r;
    out_sat_nxt   = out_sat_r;
    mem_we        = 1'b0;
    mem_waddr     = cur_r;
    mem_wdata     = '0;
    mem_re        = 1'b0;
    mem_raddr     = cur_r;
    scale_go      = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_op)
            OP_TIP: begin
              if (tip_ok) begin
                last_tip_nxt = in_now;
                mem_re       = 1'b1;
                state_nxt    = ST_TIP;
              end
            end
            OP_START: begin
              valid_nxt        = '0;
              valid_nxt[cur_r] = 1'b1;
              mem_we           = 1'b1;
              mem_wdata.stamp  = in_now;
              mem_wdata.count  = '0;
            end
            OP_QUERY: begin
              now_nxt    = in_now;
              win_nxt    = in_win;
              wstart_nxt = (in_win > in_now) ? MS_W'(1) : in_now - in_win;
              tips_nxt   = '0;
              oldest_nxt = in_now;
              idx_nxt    = '0;
              state_nxt  = ST_WALK;
            end
            default: ;
          endcase
        end
      end
      ST_TIP: begin
        // Read data of the current bucket is here; count up and write back.
        mem_we           = 1'b1;
        mem_wdata.stamp  = tip_bucket.stamp;
        mem_wdata.count  = (tip_bucket.count == COUNT_MAX) ?
                           COUNT_MAX : tip_bucket.count + 1'b1;
        valid_nxt[cur_r] = 1'b1;
        state_nxt        = ST_IDLE;
      end
      ST_WALK: begin
        mem_re    = 1'b1;
        mem_raddr = idx_r;
        idx_nxt   = idx_r + 1'b1;
        if (idx_r == IDX_W'(BUCKETS - 1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // The last bucket's data is folded into the sum at this edge.
        state_nxt = ST_ADV;
      end
      ST_ADV: begin
        if ((now_r - cur_stamp_r) > MS_W'(period_r)) begin
          cur_nxt            = cur_inc;
          mem_we             = 1'b1;
          mem_waddr          = cur_inc;
          mem_wdata.stamp    = now_r;
          mem_wdata.count    = '0;
          valid_nxt[cur_inc] = 1'b1;
        end
        scale_go  = 1'b1;
        state_nxt = ST_SCALE;
      end
      ST_SCALE: begin
        if (scale_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_rain_nxt  = scale_rsp.rain;
          out_zero_nxt  = scale_rsp.zero;
          out_sat_nxt   = scale_rsp.sat;
          out_total_nxt = (32'(tips_r) > 32'(TOTAL_MAX)) ?
                          TOTAL_MAX : TOTAL_W'(tips_r);
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Fold one returned bucket per cycle into the window sum.
    if (acc_v_r) begin
      if (rd_bucket.stamp >= wstart_r) begin
        tips_nxt = tips_r + TIPS_W'(rd_bucket.count);
        if (rd_bucket.stamp < oldest_r) begin
          oldest_nxt = rd_bucket.stamp;
        end
      end
      if (acc_idx_r == cur_r) begin
        cur_stamp_nxt = rd_bucket.stamp;
      end
    end
  end

  assign scale_req.tips = tips_r;
  assign scale_req.rpt  = rpt_r;
  assign scale_req.win  = win_r;
  assign scale_req.span = now_r - oldest_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      debounce_r  <= DEBOUNCE_RST;
      rpt_r       <= RAIN_RST;
      period_r    <= PERIOD_RST;
      cur_r       <= '0;
      last_tip_r  <= '0;
      valid_r     <= '0;
      acc_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      debounce_r  <= debounce_nxt;
      rpt_r       <= rpt_nxt;
      period_r    <= period_nxt;
      cur_r       <= cur_nxt;
      last_tip_r  <= last_tip_nxt;
      valid_r     <= valid_nxt;
      acc_v_r     <= acc_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    now_r       <= now_nxt;
    win_r       <= win_nxt;
    wstart_r    <= wstart_nxt;
    tips_r      <= tips_nxt;
    oldest_r    <= oldest_nxt;
    cur_stamp_r <= cur_stamp_nxt;
    idx_r       <= idx_nxt;
    acc_idx_r   <= acc_idx_nxt;
    out_rain_r  <= out_rain_nxt;
    out_total_r <= out_total_nxt;
    out_zero_r  <= out_zero_nxt;
    out_sat_r   <= out_sat_nxt;
  end

  rtwa_ram #(
    .WIDTH (BUCKET_W),
    .DEPTH (BUCKETS)
  ) u_bucket_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  rtwa_scale u_scale (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (scale_go),
    .req   (scale_req),
    .done  (scale_done),
    .rsp   (scale_rsp)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_total_r, out_rain_r};
  assign out_tuser  = {out_sat_r, out_zero_r};

endmodule
`default_nettype wire
